// ----- hdl/wtpl_pkg.sv -----
// Shared constants, codes and types for the weighted tree path length core.
package wtpl_pkg;

  localparam int LBL_W           = 10;
  localparam int W_IN            = 16;
  localparam int DIST_W          = 26;
  localparam int PADDR_W         = 3;
  localparam int NODES_DEF       = 1024;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [LBL_W-1:0]  ROOT_RESET = LBL_W'(1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic REG_ROOT = 1'b0;

  typedef struct packed {
    logic              mv_x;
    logic              mv_y;
    logic [DIST_W-1:0] path_sum;
  } step_t;

endpackage

// ----- hdl/weighted_tree_path_length_core.sv -----
// Weighted tree path length core: edge insert and distance query by ancestor climbing.
// Edge transaction: states RX, CX, CY and DEC in order, then a registered result strobe.
// Query transaction: the same states, then per ancestor step a re-read of the moved nodes (RX, CX
// and/or RY, CY) through one shared memory read port, and DEC again.
// Reset, and any write of root_label, starts a clearing pass over the min(NODES,1024) node table
// entries with busy high; the result strobe cannot be stalled by the receiver.
module weighted_tree_path_length_core #(
  parameter int NODES       = wtpl_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = wtpl_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [wtpl_pkg::LBL_W-1:0]    in_node_a,
  input  logic [wtpl_pkg::LBL_W-1:0]    in_node_b,
  input  logic [wtpl_pkg::W_IN-1:0]     in_weight,
  output logic                          out_valid,
  output logic [wtpl_pkg::DIST_W-1:0]   out_distance,
  output logic [1:0]                    out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtpl_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wtpl_pkg::*;

  localparam int DEPTH = (NODES < (1 << LBL_W)) ? NODES : (1 << LBL_W);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int WS    = (WEIGHT_BITS < W_IN) ? WEIGHT_BITS : W_IN;
  localparam int ENT_W = 1 + LBL_W + WS + IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_RX    = 3'd2;
  localparam logic [2:0] S_CX    = 3'd3;
  localparam logic [2:0] S_RY    = 3'd4;
  localparam logic [2:0] S_CY    = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [LBL_W-1:0]  root_r, root_nxt;
  logic              act_r, act_nxt;
  logic [WS-1:0]     w_r, w_nxt;
  logic              need_y_r, need_y_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;

  logic [LBL_W-1:0]  x_lbl_r, x_lbl_nxt, y_lbl_r, y_lbl_nxt;
  logic              x_kn_r, x_kn_nxt, y_kn_r, y_kn_nxt;
  logic [LBL_W-1:0]  x_par_r, x_par_nxt, y_par_r, y_par_nxt;
  logic [WS-1:0]     x_wt_r, x_wt_nxt, y_wt_r, y_wt_nxt;
  logic [IDX_W-1:0]  x_dep_r, x_dep_nxt, y_dep_r, y_dep_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              cfg_wr;
  logic              root_ok;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [ENT_W-1:0]  wdata, rdata;

  logic              rd_known;
  logic [LBL_W-1:0]  rd_par;
  logic [WS-1:0]     rd_wt;
  logic [IDX_W-1:0]  rd_dep;
  logic [LBL_W-1:0]  cur_lbl;
  logic              cur_root;
  logic              cur_known;
  logic [IDX_W-1:0]  cur_dep;

  logic              edge_ok;
  logic [LBL_W-1:0]  child_lbl, par_lbl;
  logic [IDX_W-1:0]  par_dep;
  step_t             step;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_ROOT);
  assign prdata  = (paddr[2] == REG_ROOT) ? 32'(root_r) : '0;
  assign busy    = (state_r != S_IDLE);
  assign root_ok = (32'(root_r) < NODES);

  assign rd_known = rdata[ENT_W-1];
  assign rd_par   = rdata[ENT_W-2 -: LBL_W];
  assign rd_wt    = rdata[IDX_W +: WS];
  assign rd_dep   = rdata[IDX_W-1:0];

  // entry view of the node whose read data is arriving; root needs no table entry
  always_comb begin
    cur_lbl   = (state_r == S_CX) ? x_lbl_r : y_lbl_r;
    cur_root  = root_ok && (cur_lbl == root_r);
    cur_known = (32'(cur_lbl) < NODES) && (cur_root || rd_known);
    cur_dep   = cur_root ? '0 : rd_dep;
  end

  always_comb begin
    child_lbl = x_kn_r ? y_lbl_r : x_lbl_r;
    par_lbl   = x_kn_r ? x_lbl_r : y_lbl_r;
    par_dep   = x_kn_r ? x_dep_r : y_dep_r;
    edge_ok   = (x_kn_r != y_kn_r) && (32'(child_lbl) < NODES);
  end

  wtpl_step_unit #(
    .WS    (WS),
    .IDX_W (IDX_W)
  ) u_step (
    .acc   (dist_r),
    .x_dep (x_dep_r),
    .y_dep (y_dep_r),
    .x_wt  (x_wt_r),
    .y_wt  (y_wt_r),
    .step  (step)
  );

  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_r;
    wdata = '0;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
    end else if (state_r == S_DEC && act_r == ACT_EDGE && edge_ok) begin
      we    = 1'b1;
      waddr = child_lbl[IDX_W-1:0];
      wdata = {1'b1, par_lbl, w_r, par_dep + IDX_W'(1)};
    end
    raddr = (state_r == S_RX) ? x_lbl_r[IDX_W-1:0] : y_lbl_r[IDX_W-1:0];
  end

  wtpl_node_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    root_nxt       = root_r;
    act_nxt        = act_r;
    w_nxt          = w_r;
    need_y_nxt     = need_y_r;
    dist_nxt       = dist_r;
    x_lbl_nxt      = x_lbl_r;
    y_lbl_nxt      = y_lbl_r;
    x_kn_nxt       = x_kn_r;
    y_kn_nxt       = y_kn_r;
    x_par_nxt      = x_par_r;
    y_par_nxt      = y_par_r;
    x_wt_nxt       = x_wt_r;
    y_wt_nxt       = y_wt_r;
    x_dep_nxt      = x_dep_r;
    y_dep_nxt      = y_dep_r;
    out_valid_nxt  = 1'b0;
    out_dist_nxt   = out_dist_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt    = in_action;
          x_lbl_nxt  = in_node_a;
          y_lbl_nxt  = in_node_b;
          w_nxt      = in_weight[WS-1:0];
          dist_nxt   = '0;
          need_y_nxt = 1'b1;
          state_nxt  = S_RX;
        end
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RX: begin
        state_nxt = S_CX;
      end
      S_CX: begin
        x_kn_nxt  = cur_known;
        x_par_nxt = rd_par;
        x_wt_nxt  = rd_wt;
        x_dep_nxt = cur_dep;
        state_nxt = need_y_r ? S_CY : S_DEC;
      end
      S_RY: begin
        state_nxt = S_CY;
      end
      S_CY: begin
        y_kn_nxt  = cur_known;
        y_par_nxt = rd_par;
        y_wt_nxt  = rd_wt;
        y_dep_nxt = cur_dep;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        if (act_r == ACT_EDGE) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = '0;
          out_status_nxt = edge_ok ? ST_OK : ST_REJECT;
          state_nxt      = S_IDLE;
        end else if (!x_kn_r || !y_kn_r) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = '0;
          out_status_nxt = ST_UNKNOWN;
          state_nxt      = S_IDLE;
        end else if (x_lbl_r == y_lbl_r) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = dist_r;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          dist_nxt   = step.path_sum;
          need_y_nxt = step.mv_y;
          if (step.mv_x) begin
            x_lbl_nxt = x_par_r;
          end
          if (step.mv_y) begin
            y_lbl_nxt = y_par_r;
          end
          state_nxt = step.mv_x ? S_RX : S_RY;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      root_nxt    = pwdata[LBL_W-1:0];
      clr_cnt_nxt = '0;
      state_nxt   = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      root_r      <= ROOT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    w_r          <= w_nxt;
    need_y_r     <= need_y_nxt;
    dist_r       <= dist_nxt;
    x_lbl_r      <= x_lbl_nxt;
    y_lbl_r      <= y_lbl_nxt;
    x_kn_r       <= x_kn_nxt;
    y_kn_r       <= y_kn_nxt;
    x_par_r      <= x_par_nxt;
    y_par_r      <= y_par_nxt;
    x_wt_r       <= x_wt_nxt;
    y_wt_r       <= y_wt_nxt;
    x_dep_r      <= x_dep_nxt;
    y_dep_r      <= y_dep_nxt;
    out_dist_r   <= out_dist_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_status   = out_status_r;

  a_result_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_DEC))
    else $error("result strobe without a decide cycle");

  a_error_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_dist_r == '0))
    else $error("error result carries a distance");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_REJECT ||
                     out_status_r == ST_UNKNOWN))
    else $error("bad status code");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction taken but core not busy");

endmodule

// ----- hdl/wtpl_node_ram.sv -----
// Node table memory: one write port, one read port with registered data.
module wtpl_node_ram #(
  parameter int DEPTH  = wtpl_pkg::NODES_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  import wtpl_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/wtpl_step_unit.sv -----
// Climb step unit: depth compare and saturating weight accumulate.
module wtpl_step_unit #(
  parameter int WS    = wtpl_pkg::W_IN,
  parameter int IDX_W = 10
) (
  input  logic [wtpl_pkg::DIST_W-1:0] acc,
  input  logic [IDX_W-1:0]            x_dep,
  input  logic [IDX_W-1:0]            y_dep,
  input  logic [WS-1:0]               x_wt,
  input  logic [WS-1:0]               y_wt,
  output wtpl_pkg::step_t             step
);
  import wtpl_pkg::*;

  logic              mv_x;
  logic              mv_y;
  logic [DIST_W:0]   sum;

  always_comb begin
    mv_x = (x_dep >= y_dep);
    mv_y = (y_dep >= x_dep);
    sum  = {1'b0, acc}
         + (mv_x ? (DIST_W+1)'(x_wt) : '0)
         + (mv_y ? (DIST_W+1)'(y_wt) : '0);
    step.mv_x     = mv_x;
    step.mv_y     = mv_y;
    step.path_sum = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

endmodule

// ----- dv/weighted_tree_path_length_core_tb.sv -----
// Testbench for the weighted tree path length core: edge and query traffic against a tree model.
`timescale 1ns / 100ps

module weighted_tree_path_length_core_tb;
  import wtpl_pkg::*;

  localparam int CLK_HALF  = 6;
  localparam int DRAIN     = 12;
  localparam int RUN_LIMIT = 8_000_000;
  localparam logic [PADDR_W-1:0] ROOT_ADDR  = PADDR_W'(4 * int'(REG_ROOT));
  // word index 1 holds no register
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

  typedef struct packed {
    logic              act;
    logic [LBL_W-1:0]  a;
    logic [LBL_W-1:0]  b;
    logic [W_IN-1:0]   w;
  } tree_op_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_sum;
    logic [1:0]        status;
  } tree_resp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_action = ACT_EDGE;
  logic [LBL_W-1:0]    in_node_a = '0;
  logic [LBL_W-1:0]    in_node_b = '0;
  logic [W_IN-1:0]     in_weight = '0;
  logic                out_valid;
  logic [DIST_W-1:0]   out_distance;
  logic [1:0]          out_status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // tree model state
  logic [LBL_W-1:0]    root_lbl;
  logic                known_tab  [NODES_DEF];
  logic [LBL_W-1:0]    parent_tab [NODES_DEF];
  logic [W_IN-1:0]     weight_tab [NODES_DEF];
  logic [LBL_W-1:0]    depth_tab  [NODES_DEF];

  tree_resp_t          results_due[$];
  logic [LBL_W-1:0]    members[$];
  int                  idle_pct;
  int                  mismatches = 0;
  int                  cycle_count = 0;

  weighted_tree_path_length_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .in_weight    (in_weight),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_status   (out_status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (mismatches < 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endfunction

  function automatic void clear_tree_model();
    for (int i = 0; i < NODES_DEF; i++) begin
      known_tab[i]  = 1'b0;
      parent_tab[i] = '0;
      weight_tab[i] = '0;
      depth_tab[i]  = '0;
    end
    known_tab[root_lbl] = 1'b1;
  endfunction

  function automatic tree_resp_t predict_tree_op(input tree_op_t op);
    tree_resp_t       r;
    logic             ka, kb;
    logic [LBL_W-1:0] par, kid, x, y;
    longint           sum;
    int               guard;
    r.path_sum = '0;
    r.status   = ST_OK;
    ka = known_tab[op.a];
    kb = known_tab[op.b];
    if (op.act == ACT_EDGE) begin
      if (ka == kb) begin
        r.status = ST_REJECT;
      end else begin
        par = ka ? op.a : op.b;
        kid = ka ? op.b : op.a;
        known_tab[kid]  = 1'b1;
        parent_tab[kid] = par;
        weight_tab[kid] = op.w;
        depth_tab[kid]  = depth_tab[par] + 1'b1;
      end
    end else if (!ka || !kb) begin
      r.status = ST_UNKNOWN;
    end else begin
      x = op.a;
      y = op.b;
      sum = 0;
      guard = 0;
      while (x != y && guard < 2 * NODES_DEF) begin
        if (depth_tab[x] >= depth_tab[y] && depth_tab[y] >= depth_tab[x]) begin
          sum += weight_tab[x] + weight_tab[y];
          x = parent_tab[x];
          y = parent_tab[y];
        end else if (depth_tab[x] > depth_tab[y]) begin
          sum += weight_tab[x];
          x = parent_tab[x];
        end else begin
          sum += weight_tab[y];
          y = parent_tab[y];
        end
        if (sum > longint'(DIST_MAX)) sum = longint'(DIST_MAX);
        guard++;
      end
      r.path_sum = DIST_W'(sum);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tree_resp_t want;
    if (rst_n && out_valid) begin
      if (results_due.size() == 0) begin
        note_mismatch("unrequested transaction", '0, 32'({out_distance, out_status}));
      end else begin
        want = results_due.pop_front();
        if (out_distance !== want.path_sum)
          note_mismatch("distance", 32'(want.path_sum), 32'(out_distance));
        if (out_status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  task automatic send_op(input logic act, input logic [LBL_W-1:0] a,
                         input logic [LBL_W-1:0] b, input logic [W_IN-1:0] w);
    tree_op_t op;
    int       gap;
    op.act = act;
    op.a   = a;
    op.b   = b;
    op.w   = w;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(12, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_node_a <= a;
    in_node_b <= b;
    in_weight <= w;
    do @(posedge clk); while (busy);
    results_due.push_back(predict_tree_op(op));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ROOT_ADDR) begin
      root_lbl = data[LBL_W-1:0];
      clear_tree_model();
      members.delete();
      members.push_back(root_lbl);
    end
  endtask

  task automatic check_root_readback();
    logic [31:0] rd;
    logic        rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ROOT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rd  = prdata;
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {{(32 - LBL_W){1'b0}}, root_lbl}) note_mismatch("root_label readback",
                                                            root_lbl, rd);
  endtask

  task automatic set_root(input logic [LBL_W-1:0] lbl);
    wait_idle();
    apb_write(ROOT_ADDR, {(32 - LBL_W)'($urandom_range(32'h003F_FFFF)), lbl});
    check_root_readback();
  endtask

  function automatic logic [LBL_W-1:0] fresh_label();
    logic [LBL_W-1:0] r;
    do r = LBL_W'($urandom_range(NODES_DEF - 1)); while (known_tab[r]);
    return r;
  endfunction

  function automatic logic [LBL_W-1:0] any_member();
    return members[$urandom_range(members.size() - 1)];
  endfunction

  function automatic logic [W_IN-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return W_IN'($urandom());
    endcase
  endfunction

  task automatic run_tree_traffic(input int n_ops, input int chain_pct);
    int               pick;
    logic [LBL_W-1:0] par, kid, x, y;
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(99);
      if (pick < 45 && members.size() < 900) begin
        par = ($urandom_range(99) < chain_pct) ? members[$] : any_member();
        kid = fresh_label();
        if ($urandom_range(1)) send_op(ACT_EDGE, par, kid, rand_weight());
        else send_op(ACT_EDGE, kid, par, rand_weight());
        members.push_back(kid);
      end else if (pick < 80) begin
        x = (chain_pct > 0 && $urandom_range(3) == 0) ? members[$] : any_member();
        y = ($urandom_range(9) == 0) ? x : any_member();
        send_op(ACT_QUERY, x, y, rand_weight());
      end else begin
        case ($urandom_range(2))
          0: send_op(1'($urandom_range(1)), LBL_W'($urandom_range(NODES_DEF - 1)),
                     LBL_W'($urandom_range(NODES_DEF - 1)), W_IN'($urandom()));
          1: send_op(ACT_EDGE, any_member(), any_member(), rand_weight());
          default: begin
            x = any_member();
            y = fresh_label();
            if ($urandom_range(1)) send_op(ACT_QUERY, x, y, rand_weight());
            else send_op(ACT_QUERY, y, x, rand_weight());
          end
        endcase
      end
    end
  endtask

  // tree built from the reset root; covers rejects, unknown nodes and both climb modes
  task automatic test_edge_and_query_basics();
    idle_pct = 38;
    send_op(ACT_QUERY, 10'd1,    10'd1,    16'h1234);
    send_op(ACT_EDGE,  10'd1,    10'd5,    16'hFFFF);
    send_op(ACT_EDGE,  10'd5,    10'd1,    16'h0007);
    send_op(ACT_EDGE,  10'd7,    10'd8,    16'h0003);
    send_op(ACT_EDGE,  10'd1,    10'd1,    16'h0000);
    send_op(ACT_QUERY, 10'd5,    10'd1,    16'hFFFF);
    send_op(ACT_QUERY, 10'd1,    10'd9,    16'h0000);
    send_op(ACT_QUERY, 10'd9,    10'd5,    16'h0000);
    send_op(ACT_QUERY, 10'd9,    10'd9,    16'h0000);
    send_op(ACT_EDGE,  10'd6,    10'd5,    16'h0000);
    send_op(ACT_EDGE,  10'd1023, 10'd1,    16'h0001);
    send_op(ACT_EDGE,  10'd1,    10'd0,    16'h8000);
    send_op(ACT_EDGE,  10'd0,    10'd1023, 16'hAAAA);
    send_op(ACT_QUERY, 10'd5,    10'd1023, 16'h0000);
    send_op(ACT_QUERY, 10'd6,    10'd0,    16'h0000);
    send_op(ACT_QUERY, 10'd6,    10'd6,    16'h0000);
    send_op(ACT_QUERY, 10'd1023, 10'd0,    16'h0000);
    send_op(ACT_EDGE,  10'd2,    10'd6,    16'h5555);
    send_op(ACT_QUERY, 10'd2,    10'd1023, 16'hFFFF);
    send_op(ACT_QUERY, 10'd0,    10'd2,    16'h0000);
    send_op(ACT_QUERY, 10'd1022, 10'd1023, 16'h0000);
    send_op(ACT_EDGE,  10'd1022, 10'd1021, 16'h0000);
    wait_idle();
  endtask

  task automatic test_root_low_traffic();
    idle_pct = 38;
    set_root('0);
    run_tree_traffic(185, 20);
    wait_idle();
  endtask

  // write to an unmapped word: tree must survive
  task automatic test_unused_register();
    idle_pct = 60;
    wait_idle();
    apb_write(SPARE_ADDR, $urandom());
    check_root_readback();
    send_op(ACT_QUERY, members[$], root_lbl, 16'h0000);
    send_op(ACT_QUERY, any_member(), any_member(), 16'h0000);
    wait_idle();
  endtask

  task automatic test_root_high_traffic();
    idle_pct = 60;
    set_root('1);
    run_tree_traffic(185, 30);
    wait_idle();
  endtask

  task automatic test_deep_chains();
    idle_pct = 0;
    set_root(LBL_W'($urandom_range(NODES_DEF - 2, 1)));
    run_tree_traffic(190, 85);
    wait_idle();
  endtask

  initial begin
    root_lbl = ROOT_RESET;
    clear_tree_model();
    members.push_back(root_lbl);
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_and_query_basics();
    test_root_low_traffic();
    test_unused_register();
    test_root_high_traffic();
    test_deep_chains();
    wait_idle();
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- weighted_tree_path_length_core.f -----
hdl/wtpl_pkg.sv
hdl/wtpl_node_ram.sv
hdl/wtpl_step_unit.sv
hdl/weighted_tree_path_length_core.sv
dv/weighted_tree_path_length_core_tb.sv
